// File: hw/rtl/pcmm_pkg.sv
// Shared types, constants and codes for the PCM byte stream to mono converter.
package pcmm_pkg;

   localparam int MAX_CHANNELS     = 8;
   localparam int MAX_SAMPLE_BYTES = 4;
   localparam int QUEUE_DEPTH      = 4;
   // Frame byte position; the divide-by-three reciprocal in the front assumes 5 bits.
   localparam int POS_W            = $clog2(MAX_CHANNELS * MAX_SAMPLE_BYTES);

   // Configuration register indexes (byte address is four times the index).
   localparam logic [1:0] REG_NUM_CHANNELS = 2'd0;
   localparam logic [1:0] REG_SAMPLE_BYTES = 2'd1;
   localparam logic [1:0] REG_STEREO_MODE  = 2'd2;

   // Stereo mode register codes.
   localparam logic [1:0] STEREO_AVERAGE = 2'd0;
   localparam logic [1:0] STEREO_LEFT    = 2'd1;
   localparam logic [1:0] STEREO_RIGHT   = 2'd2;

   // How the back end forms the output of a frame.
   localparam logic [1:0] MIX_FIRST  = 2'd0;
   localparam logic [1:0] MIX_SECOND = 2'd1;
   localparam logic [1:0] MIX_AVG    = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       packet_end;
   } pcmm_req_type;

   typedef struct packed {
      logic signed [15:0] mono_sample;
      logic               last_of_packet;
   } pcmm_rsp_type;

   typedef struct packed {
      logic [3:0] num_channels;
      logic [2:0] sample_bytes;
      logic [1:0] stereo_mode;
   } pcmm_cfg_type;

   // One completed sample handed from the front to the back.
   typedef struct packed {
      logic signed [15:0] value;
      logic               chan0;
      logic               frame_end;
      logic               packet_end;
      logic [1:0]         mix;
   } pcmm_entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } pcmm_qstat_type;

endpackage

// File: hw/rtl/pcmm_front.sv
// Front end: tracks the frame position, assembles sample bytes and queues finished samples.
module pcmm_front import pcmm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  pcmm_cfg_type   cfg,
   input  logic           accept,
   input  pcmm_req_type   req,
   output logic           push,
   output pcmm_entry_type entry
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [31:0]      asm_ff, asm_in;

   logic [3:0]       ch_eff;
   logic [2:0]       nb_eff;
   logic [6:0]       frame;
   logic             frame_zero;
   logic [POS_W-1:0] pos;
   logic [8:0]       prod3;
   logic [3:0]       quot3;
   logic [POS_W-1:0] rem3;
   logic [1:0]       k;
   logic             sample_done;
   logic             frame_done;
   logic [31:0]      word;
   logic [15:0]      value;

   always_comb begin
      ch_eff = (cfg.num_channels > 4'(MAX_CHANNELS)) ? 4'(MAX_CHANNELS) : cfg.num_channels;
      nb_eff = (cfg.sample_bytes > 3'(MAX_SAMPLE_BYTES)) ? 3'(MAX_SAMPLE_BYTES)
                                                          : cfg.sample_bytes;
      frame      = 7'(ch_eff) * 7'(nb_eff);
      frame_zero = (ch_eff == 4'd0) || (nb_eff == 3'd0);
      // A position left beyond the frame by a reconfiguration starts a new frame.
      pos = (7'(pos_ff) >= frame) ? '0 : pos_ff;

      // pos / 3 for pos below 32 is (pos * 11) >> 5.
      prod3 = 9'({pos, 3'b000}) + 9'({pos, 1'b0}) + 9'(pos);
      quot3 = prod3[8:5];
      rem3  = pos - POS_W'({quot3, 1'b0}) - POS_W'(quot3);

      case (nb_eff)
         3'd2:    k = {1'b0, pos[0]};
         3'd3:    k = rem3[1:0];
         3'd4:    k = pos[1:0];
         default: k = 2'd0;
      endcase

      sample_done = (3'(k) == nb_eff - 3'd1);
      frame_done  = sample_done && (7'(pos) == frame - 7'd1);

      // Little-endian merge: the first byte of a sample starts it afresh, and each
      // later byte is ORed into its lane on top of whatever the word already holds.
      if (k == 2'd0) begin
         word = {24'd0, req.data_byte};
      end else begin
         word = asm_ff;
         word[{k, 3'b000} +: 8] = asm_ff[{k, 3'b000} +: 8] | req.data_byte;
      end

      case (nb_eff)
         3'd2:    value = word[15:0];
         3'd3:    value = word[23:8];
         3'd4:    value = word[31:16];
         default: value = 16'd0;
      endcase

      entry.value      = value;
      entry.chan0      = (pos < POS_W'(nb_eff));
      entry.frame_end  = frame_done;
      entry.packet_end = req.packet_end;
      if (ch_eff == 4'd2) begin
         unique case (cfg.stereo_mode)
            STEREO_LEFT:  entry.mix = MIX_FIRST;
            STEREO_RIGHT: entry.mix = MIX_SECOND;
            default:      entry.mix = MIX_AVG;
         endcase
      end else begin
         entry.mix = MIX_FIRST;
      end

      push = accept && !frame_zero && sample_done;

      pos_in = pos_ff;
      asm_in = asm_ff;
      if (accept) begin
         if (frame_zero) begin
            pos_in = '0;
         end else begin
            asm_in = word;
            if (frame_done || req.packet_end) begin
               pos_in = '0;
            end else begin
               pos_in = pos + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
      asm_ff <= asm_in;
   end

endmodule

// File: hw/rtl/pcmm_queue.sv
// Short queue of finished samples between the front and the back.
module pcmm_queue import pcmm_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  pcmm_entry_type push_data,
   input  logic           pop,
   output pcmm_entry_type head,
   output pcmm_qstat_type stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   pcmm_entry_type   slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      stat.empty = (count_ff == '0);
      stat.full  = (count_ff == CNT_W'(DEPTH));
      head       = slots_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !stat.full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !stat.empty)
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("queue count did not follow a write");

endmodule

// File: hw/rtl/pcmm_back.sv
// Back end: keeps channel 0 of the frame, mixes the frame down and holds the output beat.
module pcmm_back import pcmm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  pcmm_entry_type head,
   input  pcmm_qstat_type stat,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output pcmm_rsp_type   rsp_payload
);

   logic signed [15:0] first_ff, first_in;
   logic               rsp_valid_ff, rsp_valid_in;
   pcmm_rsp_type       rsp_ff, rsp_in;

   logic               out_free;
   logic               load;
   logic signed [16:0] sum;
   logic        [16:0] sum_adj;
   logic signed [15:0] result;

   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      pop      = !stat.empty && (!head.frame_end || out_free);
      load     = pop && head.frame_end;

      first_in = first_ff;
      if (pop && head.chan0) begin
         first_in = head.value;
      end

      // Halving that truncates toward zero: add one to a negative sum before the shift.
      sum     = 17'(first_in) + 17'(head.value);
      sum_adj = 17'(sum) + 17'(sum[16]);

      unique case (head.mix)
         MIX_SECOND: result = head.value;
         MIX_AVG:    result = sum_adj[16:1];
         default:    result = first_in;
      endcase

      rsp_in = rsp_ff;
      if (load) begin
         rsp_in.mono_sample    = result;
         rsp_in.last_of_packet = head.packet_end;
      end

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      rsp_valid   = rsp_valid_ff;
      rsp_payload = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         first_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         first_ff     <= first_in;
      end
      rsp_ff <= rsp_in;
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> out_free)
      else $error("output beat overwritten before it was taken");

   a_held_beat_kept: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !load)
      else $error("stalled output beat replaced");

endmodule

// File: hw/rtl/pcm_frames_to_mono16_core.sv
// Top level of the interleaved PCM byte stream to mono 16-bit converter.
//
// Bytes of a little-endian interleaved PCM stream enter on the req_ channel,
// one byte per beat, with packet_end marking the last byte of a packet. Each
// complete frame of num_channels samples of sample_bytes bytes gives one beat
// on the rsp_ channel: the 16-bit mono sample and whether the frame closed
// the packet. A partial frame at a packet end gives no beat.
// The configuration registers sit on an APB-style port at byte addresses
// 0 (num_channels), 4 (sample_bytes) and 8 (stereo_mode); write them only
// while no frame is in flight.
// One byte is accepted every cycle while req_stall is low. The result of a
// frame passes the sample queue and then the output register before it is
// valid on the rsp_ channel. When rsp_stall is high a valid output beat holds,
// the back end stops before the last sample of a frame, and the front keeps
// taking bytes until the four-entry sample queue fills; req_stall then rises.
// Reset clears the frame position, the queue, the output beat and the
// registers (one channel, three bytes per sample, averaging).
module pcm_frames_to_mono16_core import pcmm_pkg::*; #(
   parameter int Q_DEPTH = QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  pcmm_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output pcmm_rsp_type rsp_payload,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [3:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   pcmm_cfg_type   cfg_ff, cfg_in;
   logic           cfg_write;
   logic [1:0]     reg_index;
   logic           accept;
   logic           push;
   logic           pop;
   pcmm_entry_type push_data;
   pcmm_entry_type head;
   pcmm_qstat_type stat;

   always_comb begin
      pready    = 1'b1;
      reg_index = paddr[3:2];
      cfg_write = psel && penable && pwrite && pready;

      cfg_in = cfg_ff;
      if (cfg_write) begin
         unique case (reg_index)
            REG_NUM_CHANNELS: cfg_in.num_channels = pwdata[3:0];
            REG_SAMPLE_BYTES: cfg_in.sample_bytes = pwdata[2:0];
            REG_STEREO_MODE:  cfg_in.stereo_mode  = pwdata[1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end

      unique case (reg_index)
         REG_NUM_CHANNELS: prdata = 32'(cfg_ff.num_channels);
         REG_SAMPLE_BYTES: prdata = 32'(cfg_ff.sample_bytes);
         REG_STEREO_MODE:  prdata = 32'(cfg_ff.stereo_mode);
         default:          prdata = 32'd0;
      endcase

      req_stall = stat.full;
      accept    = req_valid && !req_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_channels <= 4'd1;
         cfg_ff.sample_bytes <= 3'd3;
         cfg_ff.stereo_mode  <= STEREO_AVERAGE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pcmm_front u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .accept (accept),
      .req    (req_payload),
      .push   (push),
      .entry  (push_data)
   );

   pcmm_queue #(
      .DEPTH (Q_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .stat      (stat)
   );

   pcmm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .stat        (stat),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
